// ===== design/pfp_pkg.sv =====
// Package for the provisioning frame parser.
// Frame constants, parse phase and verdict codes, and the result record.
// No dependencies.
package pfp_pkg;

  localparam int unsigned HdrLen = 6;
  localparam int unsigned TdataW = 64;

  localparam logic [7:0] TypeCommand = 8'h03;
  localparam logic [7:0] CmdCreds    = 8'h01;
  localparam logic [7:0] CmdIdent    = 8'h02;
  localparam logic [7:0] CmdInfo     = 8'h03;
  localparam logic [7:0] CredsMinLen = 8'd3;

  typedef logic [7:0] hdr_text_t [HdrLen];
  localparam hdr_text_t HdrText = '{8'h49, 8'h4D, 8'h50, 8'h52, 8'h4F, 8'h56};

  typedef enum logic [2:0] {
    PhHeader  = 3'd0,
    PhVersion = 3'd1,
    PhType    = 3'd2,
    PhLength  = 3'd3,
    PhPayload = 3'd4,
    PhCheck   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    VerdNone     = 3'd0,
    VerdBadSum   = 3'd1,
    VerdNotCmd   = 3'd2,
    VerdInvalid  = 3'd3,
    VerdCredsOk  = 3'd4,
    VerdIdentify = 3'd5,
    VerdInfo     = 3'd6,
    VerdUnknown  = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       is_payload;
    logic [7:0] payload_index;
    logic       frame_done;
    logic [7:0] frame_type;
    logic [7:0] payload_length;
    verdict_e   verdict;
    logic [7:0] command_code;
    logic [7:0] ssid_length;
    logic [7:0] password_length;
  } result_t;

endpackage

// ===== design/provisioning_frame_parser.sv =====
// Provisioning frame parser: one result per received byte.
// Path: input register, then result register, with the decode between the two.
// Throughput: one byte per cycle while m_axis_tready_i does not stall the output.
// Reset: asynchronous, active low; parser returns to header hunt with all held fields zero.
// Both stages empty after reset. Depends on pfp_pkg and pfp_core.
module provisioning_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] echo_byte, [15:8] payload_index, [23:16] frame_type,
  // [31:24] payload_length, [34:32] verdict, [42:35] command_code,
  // [50:43] ssid_length, [58:51] password_length, [63:59] zero
  output logic [pfp_pkg::TdataW-1:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // frame_done
  output logic        m_axis_tuser_o    // is_payload
);

  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             out_vld_q;
  pfp_pkg::result_t res;
  pfp_pkg::result_t res_q;
  logic             adv;
  logic             in_acc;

  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  pfp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .rx_byte_i (in_byte_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = res_q.frame_done;
  assign m_axis_tuser_o  = res_q.is_payload;
  assign m_axis_tdata_o  = {5'b0, res_q.password_length, res_q.ssid_length,
                            res_q.command_code, res_q.verdict, res_q.payload_length,
                            res_q.frame_type, res_q.payload_index, res_q.echo_byte};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[34:32] != pfp_pkg::VerdNone)
    else $error("frame end without verdict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[58:16] == '0)
    else $error("frame fields set on a byte that does not end a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o && m_axis_tlast_o))
    else $error("byte flagged both payload and frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q && res_q.echo_byte == $past(in_byte_q))
    else $error("result register missed an advanced byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i && in_vld_q |-> !s_axis_tready_o)
    else $error("input taken while both stages are stalled");

endmodule

// ===== design/pfp_core.sv =====
// Parse state and per-byte decode of the provisioning frame parser.
// Holds the frame state; updates it on each advanced transaction.
// Depends on pfp_pkg.
module pfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [7:0]        rx_byte_i,
  output pfp_pkg::result_t  res_o
);

  pfp_pkg::phase_e phase_q, phase_d;
  logic [2:0] hdr_pos_q, hdr_pos_d;
  logic [7:0] type_q, type_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] ssid_q, ssid_d;
  logic [7:0] pw_q, pw_d;

  logic [7:0] sum_add;
  logic [7:0] cnt_inc;
  logic [8:0] pw_pos;
  logic [9:0] pw_end;
  logic       hdr_hit;
  pfp_pkg::verdict_e cmd_verdict;

  assign sum_add = sum_q + rx_byte_i;
  assign cnt_inc = cnt_q + 8'd1;
  assign pw_pos  = {1'b0, ssid_q} + 9'd2;
  assign pw_end  = {1'b0, pw_pos} + {2'b0, pw_q} + 10'd1;
  assign hdr_hit = (hdr_pos_q < 3'(pfp_pkg::HdrLen)) &&
                   (rx_byte_i == pfp_pkg::HdrText[hdr_pos_q]);

  always_comb begin
    if (len_q == 8'd0) begin
      cmd_verdict = pfp_pkg::VerdInvalid;
    end else begin
      case (cmd_q)
        pfp_pkg::CmdCreds: begin
          if (len_q < pfp_pkg::CredsMinLen || pw_pos >= {1'b0, len_q} ||
              pw_end > {2'b0, len_q}) begin
            cmd_verdict = pfp_pkg::VerdInvalid;
          end else begin
            cmd_verdict = pfp_pkg::VerdCredsOk;
          end
        end
        pfp_pkg::CmdIdent: cmd_verdict = pfp_pkg::VerdIdentify;
        pfp_pkg::CmdInfo:  cmd_verdict = pfp_pkg::VerdInfo;
        default:           cmd_verdict = pfp_pkg::VerdUnknown;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    type_d    = type_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    cmd_d     = cmd_q;
    ssid_d    = ssid_q;
    pw_d      = pw_q;
    res_o     = '0;
    res_o.echo_byte = rx_byte_i;
    case (phase_q)
      pfp_pkg::PhVersion: begin
        sum_d   = rx_byte_i;
        phase_d = pfp_pkg::PhType;
      end
      pfp_pkg::PhType: begin
        type_d  = rx_byte_i;
        sum_d   = sum_add;
        phase_d = pfp_pkg::PhLength;
      end
      pfp_pkg::PhLength: begin
        len_d   = rx_byte_i;
        sum_d   = sum_add;
        cnt_d   = '0;
        cmd_d   = '0;
        ssid_d  = '0;
        pw_d    = '0;
        phase_d = (rx_byte_i != 8'd0) ? pfp_pkg::PhPayload : pfp_pkg::PhCheck;
      end
      pfp_pkg::PhPayload: begin
        res_o.is_payload    = 1'b1;
        res_o.payload_index = cnt_q;
        sum_d = sum_add;
        if (cnt_q == 8'd0) begin
          cmd_d = rx_byte_i;
        end else if (cnt_q == 8'd1) begin
          ssid_d = rx_byte_i;
        end else if ({1'b0, cnt_q} == pw_pos) begin
          pw_d = rx_byte_i;
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = pfp_pkg::PhCheck;
        end
      end
      pfp_pkg::PhCheck: begin
        res_o.frame_done      = 1'b1;
        res_o.frame_type      = type_q;
        res_o.payload_length  = len_q;
        res_o.command_code    = cmd_q;
        res_o.ssid_length     = ssid_q;
        res_o.password_length = pw_q;
        if (rx_byte_i != sum_q) begin
          res_o.verdict = pfp_pkg::VerdBadSum;
        end else if (type_q != pfp_pkg::TypeCommand) begin
          res_o.verdict = pfp_pkg::VerdNotCmd;
        end else begin
          res_o.verdict = cmd_verdict;
        end
        phase_d = pfp_pkg::PhHeader;
      end
      default: begin
        phase_d = pfp_pkg::PhHeader;
        if (hdr_hit) begin
          if (hdr_pos_q == 3'(pfp_pkg::HdrLen - 1)) begin
            hdr_pos_d = '0;
            phase_d   = pfp_pkg::PhVersion;
          end else begin
            hdr_pos_d = hdr_pos_q + 3'd1;
          end
        end else begin
          hdr_pos_d = (rx_byte_i == pfp_pkg::HdrText[0]) ? 3'd1 : 3'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pfp_pkg::PhHeader;
      hdr_pos_q <= '0;
      type_q    <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      cmd_q     <= '0;
      ssid_q    <= '0;
      pw_q      <= '0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      type_q    <= type_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      cmd_q     <= cmd_d;
      ssid_q    <= ssid_d;
      pw_q      <= pw_d;
    end
  end

  // header position only ever counts through the six header characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pos_q < 3'(pfp_pkg::HdrLen))
    else $error("header position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pfp_pkg::PhPayload |-> cnt_q < len_q)
    else $error("payload count reached length inside payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && phase_q == pfp_pkg::PhCheck |=> phase_q == pfp_pkg::PhHeader)
    else $error("frame end did not return to header hunt");

endmodule

// ===== sim/pfp_tb_pkg.sv =====
// Scoreboard for the provisioning frame parser testbench.
// Predicts one result per received byte and checks the block's results in order.
// Depends on pfp_pkg.
package pfp_tb_pkg;
  import pfp_pkg::*;

  class frame_scoreboard;
    phase_e      phase;
    logic [2:0]  hdr_pos;
    logic [7:0]  frame_type;
    logic [7:0]  frame_len;
    logic [7:0]  pay_count;
    logic [7:0]  sum;
    logic [7:0]  command;
    logic [7:0]  ssid_bytes;
    logic [7:0]  pw_len;
    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      phase      = PhHeader;
      hdr_pos    = '0;
      frame_type = '0;
      frame_len  = '0;
      pay_count  = '0;
      sum        = '0;
      command    = '0;
      ssid_bytes = '0;
      pw_len     = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function verdict_e command_verdict();
      int unsigned off;
      off = 2 + int'(ssid_bytes);
      if (frame_len == 8'd0) return VerdInvalid;
      case (command)
        CmdCreds: begin
          if (frame_len < CredsMinLen) return VerdInvalid;
          if (off >= int'(frame_len)) return VerdInvalid;
          if (off + 1 + int'(pw_len) > int'(frame_len)) return VerdInvalid;
          return VerdCredsOk;
        end
        CmdIdent: return VerdIdentify;
        CmdInfo:  return VerdInfo;
        default:  return VerdUnknown;
      endcase
    endfunction

    // Advance the parse by one byte and queue the result it causes.
    function void note_rx_byte(logic [7:0] b);
      result_t r;
      r = '0;
      r.echo_byte = b;
      case (phase)
        PhVersion: begin
          sum   = b;
          phase = PhType;
        end
        PhType: begin
          frame_type = b;
          sum        = sum + b;
          phase      = PhLength;
        end
        PhLength: begin
          frame_len  = b;
          sum        = sum + b;
          pay_count  = '0;
          command    = '0;
          ssid_bytes = '0;
          pw_len     = '0;
          phase      = (b != 8'd0) ? PhPayload : PhCheck;
        end
        PhPayload: begin
          r.is_payload    = 1'b1;
          r.payload_index = pay_count;
          sum             = sum + b;
          if (pay_count == 8'd0) command = b;
          else if (pay_count == 8'd1) ssid_bytes = b;
          else if (int'(pay_count) == 2 + int'(ssid_bytes)) pw_len = b;
          pay_count = pay_count + 8'd1;
          if (pay_count >= frame_len) phase = PhCheck;
        end
        PhCheck: begin
          r.frame_done      = 1'b1;
          r.frame_type      = frame_type;
          r.payload_length  = frame_len;
          r.command_code    = command;
          r.ssid_length     = ssid_bytes;
          r.password_length = pw_len;
          if (b != sum) r.verdict = VerdBadSum;
          else if (frame_type != TypeCommand) r.verdict = VerdNotCmd;
          else r.verdict = command_verdict();
          phase = PhHeader;
        end
        default: begin
          phase = PhHeader;
          if (hdr_pos < HdrLen && b == HdrText[hdr_pos]) begin
            if (hdr_pos == 3'(HdrLen - 1)) begin
              hdr_pos = '0;
              phase   = PhVersion;
            end else begin
              hdr_pos = hdr_pos + 3'd1;
            end
          end else begin
            hdr_pos = (b == HdrText[0]) ? 3'd1 : 3'd0;
          end
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t mismatch on result %0d: %s", $time, checked, what);
    endtask

    task compare_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    task check_result(logic [TdataW-1:0] data, logic last, logic user);
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tdata %0h", data));
        return;
      end
      want = pending_results.pop_front();
      compare_field("echo_byte", data[7:0], want.echo_byte);
      compare_field("payload_index", data[15:8], want.payload_index);
      compare_field("frame_type", data[23:16], want.frame_type);
      compare_field("payload_length", data[31:24], want.payload_length);
      compare_field("verdict", 8'(data[34:32]), 8'(want.verdict));
      compare_field("command_code", data[42:35], want.command_code);
      compare_field("ssid_length", data[50:43], want.ssid_length);
      compare_field("password_length", data[58:51], want.password_length);
      compare_field("tdata padding", 8'(data[63:59]), 8'd0);
      compare_field("frame_done", 8'(last), 8'(want.frame_done));
      compare_field("is_payload", 8'(user), 8'(want.is_payload));
      checked++;
    endtask
  endclass

endpackage

// ===== sim/testbench.sv =====
// Testbench top for the provisioning frame parser.
// Drives directed and random serial byte streams with varied idling, checks via
// the frame_scoreboard in pfp_tb_pkg. Depends on pfp_pkg, pfp_tb_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfp_pkg::*;
  import pfp_tb_pkg::*;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'h00;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [TdataW-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  int unsigned       tx_gap_pct = 0;
  int unsigned       rx_stall_pct = 0;
  int unsigned       frame_bytes = 0;
  frame_scoreboard   sb;

  provisioning_frame_parser u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_rx_byte(b);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IdleNone:     begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
      IdleSender:   begin tx_gap_pct = 71; rx_stall_pct = 0;  end
      IdleReceiver: begin tx_gap_pct = 0;  rx_stall_pct = 71; end
      default:      begin tx_gap_pct = 8;  rx_stall_pct = 8;  end
    endcase
  endtask

  // One frame with random content, mostly well formed; some get noise in front,
  // a corrupted header, a truncated tail or a bad checksum.
  task automatic send_frame();
    logic [7:0] frame[$];
    logic [7:0] cmd;
    logic [7:0] csum;
    int         len;
    int         ssid;
    int         pw;
    int         pick;
    repeat (($urandom_range(9) < 2) ? $urandom_range(1, 4) : 0) begin
      if ($urandom_range(1) != 0) put_byte(HdrText[$urandom_range(HdrLen - 1)]);
      else put_byte(8'($urandom));
    end
    pick = $urandom_range(9);
    if (pick < 4) cmd = CmdCreds;
    else if (pick < 6) cmd = CmdIdent;
    else if (pick < 8) cmd = CmdInfo;
    else cmd = 8'($urandom);
    ssid = ($urandom_range(19) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 8);
    pw   = $urandom_range(0, 8);
    pick = $urandom_range(99);
    if (pick < 4) len = $urandom_range(128, 255);
    else if (pick < 12) len = 0;
    else if (cmd == CmdCreds) len = 3 + ssid + pw + $urandom_range(3) - $urandom_range(3);
    else len = $urandom_range(1, 6);
    if (len < 0) len = 0;
    if (len > 255) len = 255;

    for (int i = 0; i < HdrLen; i++) frame.push_back(HdrText[i]);
    frame.push_back(8'($urandom));
    frame.push_back(($urandom_range(3) != 0) ? TypeCommand : 8'($urandom));
    frame.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == 0) frame.push_back(cmd);
      else if (i == 1) frame.push_back(8'(ssid));
      else if (i == 2 + ssid) frame.push_back(8'(pw));
      else frame.push_back(8'($urandom));
    end
    csum = 8'h00;
    for (int i = HdrLen; i < frame.size(); i++) csum = csum + frame[i];
    if ($urandom_range(99) < 15) csum = csum ^ 8'($urandom_range(1, 255));
    frame.push_back(csum);

    pick = $urandom_range(99);
    if (pick < 6) frame[$urandom_range(HdrLen - 1)] ^= 8'($urandom_range(1, 255));
    else if (pick < 12) frame = frame[0 : $urandom_range(1, frame.size() - 2)];

    foreach (frame[i]) put_byte(frame[i]);
    frame_bytes += frame.size();
  endtask

  initial begin
    logic [7:0] directed[$];
    int unsigned phase_no;
    sb = new();
    // extremes, a resync on a repeated 'I', a zero-length command frame and an
    // identify frame
    directed = '{8'h00, 8'hFF,
                 HdrText[0], HdrText[0], HdrText[1], HdrText[2], HdrText[3], HdrText[4],
                 HdrText[5], 8'hFF, TypeCommand, 8'h00, 8'h02,
                 HdrText[0], HdrText[1], HdrText[2], HdrText[3], HdrText[4], HdrText[5],
                 8'h01, TypeCommand, 8'h01, CmdIdent, 8'h07};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) put_byte(directed[i]);

    phase_no = 0;
    while (frame_bytes < 1450) begin
      set_idling(idle_mode_e'(phase_no % 4));
      repeat (8) begin
        if (frame_bytes < 1450) send_frame();
      end
      if (phase_no == 2) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      phase_no++;
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== provisioning_frame_parser.f =====
design/pfp_pkg.sv
design/pfp_core.sv
design/provisioning_frame_parser.sv
sim/pfp_tb_pkg.sv
sim/testbench.sv
